### hw/rtl/ascii_sum_expression_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII sum expression parser.
// Each macro expects signals named clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASCII_SUM_EXPRESSION_PARSER_UNIT_MACROS_SVH
`define ASCII_SUM_EXPRESSION_PARSER_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/asep_pkg.sv
// ----------------------------------------------------------------------------
// ASCII sum expression parser package
// Shared types and character codes of the expression parser.
// ----------------------------------------------------------------------------
`default_nettype none

package asep_pkg;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_TOO_LONG  = 2'd1,
		ERR_TOO_SHORT = 2'd2,
		ERR_MALFORMED = 2'd3
	} err_t;

	typedef enum logic {
		REG_MAX_LENGTH = 1'b0,
		REG_MIN_LENGTH = 1'b1
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned VALUE_W    = 32;

	localparam logic [CHAR_W-1:0] CHAR_PLUS     = 8'd43;
	localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_X        = 8'd120;
	localparam logic [CHAR_W-1:0] CHAR_BELOW_0  = 8'd47;
	localparam logic [CHAR_W-1:0] CHAR_ABOVE_9  = 8'd58;
	localparam logic [CHAR_W-1:0] CHAR_BELOW_A  = 8'd64;
	localparam logic [CHAR_W-1:0] CHAR_ABOVE_F  = 8'd71;
	localparam logic [CHAR_W-1:0] HEX_LETTER_OFS = 8'd55;

	localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RESET = 8'd63;
	localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RESET = 8'd1;

endpackage

`default_nettype wire

### hw/rtl/asep_in_if.sv
// ----------------------------------------------------------------------------
// ASCII sum expression parser input channel
// Carries one expression character per beat with its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface asep_in_if;

	logic                           valid;
	logic                           ready;
	logic [asep_pkg::CHAR_W-1:0]    char_in;
	logic                           last;

	modport source (output valid, output char_in, output last, input ready);
	modport sink   (input valid, input char_in, input last, output ready);

endinterface

`default_nettype wire

### hw/rtl/asep_out_if.sv
// ----------------------------------------------------------------------------
// ASCII sum expression parser output channel
// Carries one expression result per beat: the sum and an error code.
// ----------------------------------------------------------------------------
`default_nettype none

interface asep_out_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [asep_pkg::VALUE_W-1:0]  value;
	asep_pkg::err_t                       error;

	modport source (output valid, output value, output error, input ready);
	modport sink   (input valid, input value, input error, output ready);

endinterface

`default_nettype wire

### hw/rtl/ascii_sum_expression_parser_unit.sv
// ----------------------------------------------------------------------------
// ASCII sum expression parser
// Sums decimal and hexadecimal terms of a streamed ASCII expression.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock cycle with no gaps required
// between expressions, except while it holds its input off as told below,
// and returns one result beat for each beat flagged as last. The character
// is folded into the term and sum registers in the cycle it is accepted;
// the final term is then added to the sum in a second stage and the result
// sits in an output register. While a result waits at the output, input
// keeps flowing until a second result is held behind it in the second stage.
// The length limits may only be changed while no expression is in flight.
`default_nettype none

module ascii_sum_expression_parser_unit #(
	parameter int unsigned LENGTH_BITS = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire asep_pkg::cfg_index_t           wr_index,
	input  wire [asep_pkg::CFG_DATA_W-1:0]      wr_data,
	asep_in_if.sink                             in_ch,
	asep_out_if.source                          out_ch
);

	import asep_pkg::*;

	localparam int unsigned CMP_W = (LENGTH_BITS > CFG_DATA_W) ? LENGTH_BITS : CFG_DATA_W;
	localparam logic [LENGTH_BITS-1:0] LEN_SAT = {LENGTH_BITS{1'b1}};

	logic [CFG_DATA_W-1:0]   max_len_q;
	logic [CFG_DATA_W-1:0]   min_len_q;

	logic [LENGTH_BITS-1:0]  length_q;
	logic [VALUE_W-1:0]      sum_q;
	logic [VALUE_W-1:0]      term_q;
	logic                    neg_q;
	logic [1:0]              pos_q;
	logic                    hex_q;
	logic                    fz_q;
	logic                    malformed_q;

	logic [LENGTH_BITS-1:0]  length_d;
	logic [VALUE_W-1:0]      sum_d;
	logic [VALUE_W-1:0]      term_d;
	logic                    neg_d;
	logic [1:0]              pos_d;
	logic                    hex_d;
	logic                    fz_d;
	logic                    malformed_d;
	err_t                    err_d;

	logic                    valid_s1;
	logic [VALUE_W-1:0]      sum_s1;
	logic [VALUE_W-1:0]      term_s1;
	logic                    neg_s1;
	err_t                    err_s1;

	logic                    out_valid_q;
	logic [VALUE_W-1:0]      value_q;
	err_t                    error_q;

	logic                    out_free;
	logic                    in_accept;
	logic [CHAR_W-1:0]       c;
	logic                    is_op;
	logic                    is_dec;
	logic                    is_hex_letter;
	logic [VALUE_W-1:0]      dec_digit;
	logic [VALUE_W-1:0]      hex_digit;
	logic [VALUE_W-1:0]      term_x10;
	logic [VALUE_W-1:0]      fold_sum;
	logic [VALUE_W-1:0]      final_sum;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || out_free;
	assign in_accept    = in_ch.valid && in_ch.ready;

	assign c             = in_ch.char_in;
	assign is_op         = (c == CHAR_PLUS) || (c == CHAR_MINUS);
	assign is_dec        = (c > CHAR_BELOW_0) && (c < CHAR_ABOVE_9);
	assign is_hex_letter = (c > CHAR_BELOW_A) && (c < CHAR_ABOVE_F);
	assign dec_digit     = VALUE_W'(c - CHAR_ZERO);
	assign hex_digit     = VALUE_W'(c - HEX_LETTER_OFS);
	assign term_x10      = {term_q[VALUE_W-4:0], 3'b000} + {term_q[VALUE_W-2:0], 1'b0};
	assign fold_sum      = neg_q ? (sum_q - term_q) : (sum_q + term_q);

	always_comb begin
		length_d    = (length_q < LEN_SAT) ? length_q + 1'b1 : length_q;
		sum_d       = sum_q;
		term_d      = term_q;
		neg_d       = neg_q;
		pos_d       = (pos_q < 2'd2) ? pos_q + 2'd1 : pos_q;
		hex_d       = hex_q;
		fz_d        = fz_q;
		malformed_d = malformed_q;
		priority if (is_op) begin
			sum_d  = fold_sum;
			neg_d  = (c == CHAR_MINUS);
			term_d = '0;
			pos_d  = 2'd0;
			hex_d  = 1'b0;
			fz_d   = 1'b0;
		end else if ((pos_q == 2'd1) && fz_q && (c == CHAR_X)) begin
			hex_d  = 1'b1;
			term_d = '0;
		end else if (hex_q) begin
			priority if (is_dec) begin
				term_d = {term_q[VALUE_W-5:0], 4'b0000} + dec_digit;
			end else if (is_hex_letter) begin
				term_d = {term_q[VALUE_W-5:0], 4'b0000} + hex_digit;
			end else begin
				malformed_d = 1'b1;
			end
		end else if (is_dec) begin
			if (pos_q == 2'd0) begin
				fz_d = (c == CHAR_ZERO);
			end
			term_d = term_x10 + dec_digit;
		end else begin
			malformed_d = 1'b1;
		end

		priority if (CMP_W'(length_d) > CMP_W'(max_len_q)) begin
			err_d = ERR_TOO_LONG;
		end else if (CMP_W'(length_d) < CMP_W'(min_len_q)) begin
			err_d = ERR_TOO_SHORT;
		end else if (malformed_d) begin
			err_d = ERR_MALFORMED;
		end else begin
			err_d = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LENGTH_RESET;
			min_len_q <= MIN_LENGTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_LENGTH: max_len_q <= wr_data;
				REG_MIN_LENGTH: min_len_q <= wr_data;
				default:        max_len_q <= max_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			sum_q       <= '0;
			term_q      <= '0;
			neg_q       <= 1'b0;
			pos_q       <= 2'd0;
			hex_q       <= 1'b0;
			fz_q        <= 1'b0;
			malformed_q <= 1'b0;
		end else if (in_accept) begin
			if (in_ch.last) begin
				length_q    <= '0;
				sum_q       <= '0;
				term_q      <= '0;
				neg_q       <= 1'b0;
				pos_q       <= 2'd0;
				hex_q       <= 1'b0;
				fz_q        <= 1'b0;
				malformed_q <= 1'b0;
			end else begin
				length_q    <= length_d;
				sum_q       <= sum_d;
				term_q      <= term_d;
				neg_q       <= neg_d;
				pos_q       <= pos_d;
				hex_q       <= hex_d;
				fz_q        <= fz_d;
				malformed_q <= malformed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_accept && in_ch.last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && in_ch.last) begin
			sum_s1  <= sum_d;
			term_s1 <= term_d;
			neg_s1  <= neg_d;
			err_s1  <= err_d;
		end
	end

	assign final_sum = neg_s1 ? (sum_s1 - term_s1) : (sum_s1 + term_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			value_q <= (err_s1 == ERR_NONE) ? final_sum : '0;
			error_q <= err_s1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.value = value_q;
	assign out_ch.error = error_q;

`include "ascii_sum_expression_parser_unit_macros.svh"

	`ASEP_ASSERT_NEXT(a_clear_after_last, in_accept && in_ch.last, (length_q == '0) && (sum_q == '0) && (term_q == '0) && !malformed_q, "expression state not cleared after last beat")
	`ASEP_ASSERT_IMP(a_zero_on_error, out_valid_q && (error_q != ERR_NONE), value_q == '0, "nonzero value on error result")
	`ASEP_ASSERT_NEXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && $stable(sum_s1) && $stable(term_s1) && $stable(err_s1), "second stage changed while stalled")
	`ASEP_ASSERT(a_pos_range, pos_q != 2'd3, "term position out of range")
	`ASEP_ASSERT_NEXT(a_no_result_without_last, !valid_s1 && !(in_accept && in_ch.last), !valid_s1, "second stage filled without a last beat")

endmodule

`default_nettype wire

### test/tb_ascii_sum_expression_parser_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the ASCII sum expression parser unit
// Streams expressions one character beat at a time and checks every result
// beat against an in-bench model of the parser or a fixed answer: a directed
// table of corner cases first, then random well-formed and broken expressions
// under several length limits, with idle sender and stalling receiver phases
// and one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_ascii_sum_expression_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import asep_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_CHARS    = 640;
	localparam int PHASES          = 8;
	localparam int PRESSURE_PHASE  = 4;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		err_t                      error;
	} parse_result_t;

	typedef struct {
		bit            fixed;
		parse_result_t r;
	} answer_note_t;

	typedef struct {
		logic [7:0]                max_len;
		logic [7:0]                min_len;
		string                     head;
		logic [7:0]                tail;
		bit                        fixed;
		logic signed [VALUE_W-1:0] value;
		err_t                      error;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	cfg_index_t            wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	asep_in_if  char_ch ();
	asep_out_if sum_ch ();

	ascii_sum_expression_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (char_ch),
		.out_ch   (sum_ch)
	);

	always #4ns clk = ~clk;

	logic [7:0]         max_len_cfg, min_len_cfg;
	logic [7:0]         char_count;
	logic [31:0]        running_sum, term_value;
	logic [1:0]         term_chars;
	bit                 term_sub, in_hex, lead_zero, saw_bad;

	parse_result_t      pending_sums [$];
	answer_note_t       answer_notes [$];
	logic [7:0]         expr_bytes [$];

	int                 error_count    = 0;
	int                 results_seen   = 0;
	int                 chars_seen     = 0;
	int                 settings_count = 0;
	int                 hold_offs_done = 0;
	int                 send_gap_pct   = 0;
	int                 stall_pct      = 0;
	bit                 hold_off_req   = 1'b0;
	logic [7:0]         max_set        = MAX_LENGTH_RESET;
	logic [7:0]         min_set        = MIN_LENGTH_RESET;

	function automatic void clear_parser();
		char_count  = '0;
		running_sum = '0;
		term_value  = '0;
		term_chars  = '0;
		term_sub    = 1'b0;
		in_hex      = 1'b0;
		lead_zero   = 1'b0;
		saw_bad     = 1'b0;
	endfunction

	function automatic bit parse_char(input logic [7:0] c, input bit closes,
			output parse_result_t res);
		err_t err;
		res = '0;
		if (char_count != 8'hFF)
			char_count++;
		if (c == CHAR_PLUS || c == CHAR_MINUS) begin
			running_sum = term_sub ? running_sum - term_value : running_sum + term_value;
			term_sub    = (c == CHAR_MINUS);
			term_value  = '0;
			term_chars  = '0;
			in_hex      = 1'b0;
			lead_zero   = 1'b0;
		end else begin
			if (term_chars == 2'd1 && lead_zero && c == CHAR_X) begin
				in_hex     = 1'b1;
				term_value = '0;
			end else if (in_hex && c > CHAR_BELOW_0 && c < CHAR_ABOVE_9) begin
				term_value = (term_value << 4) + 32'(c - CHAR_ZERO);
			end else if (in_hex && c > CHAR_BELOW_A && c < CHAR_ABOVE_F) begin
				term_value = (term_value << 4) + 32'(c - HEX_LETTER_OFS);
			end else if (!in_hex && c > CHAR_BELOW_0 && c < CHAR_ABOVE_9) begin
				if (term_chars == 2'd0)
					lead_zero = (c == CHAR_ZERO);
				term_value = term_value * 10 + 32'(c - CHAR_ZERO);
			end else begin
				saw_bad = 1'b1;
			end
			if (term_chars != 2'd2)
				term_chars++;
		end
		if (!closes)
			return 1'b0;
		running_sum = term_sub ? running_sum - term_value : running_sum + term_value;
		if (char_count > max_len_cfg)
			err = ERR_TOO_LONG;
		else if (char_count < min_len_cfg)
			err = ERR_TOO_SHORT;
		else if (saw_bad)
			err = ERR_MALFORMED;
		else
			err = ERR_NONE;
		res.value = (err == ERR_NONE) ? running_sum : '0;
		res.error = err;
		clear_parser();
		return 1'b1;
	endfunction

	initial begin
		max_len_cfg = MAX_LENGTH_RESET;
		min_len_cfg = MIN_LENGTH_RESET;
		clear_parser();
	end

	always @(posedge clk) begin : beat_monitor
		parse_result_t want, pred;
		answer_note_t  note;
		if (arst_n) begin
			if (sum_ch.valid && sum_ch.ready) begin
				if (pending_sums.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat, value %0d error %s", $time,
						sum_ch.value, sum_ch.error.name());
				end else begin
					want = pending_sums.pop_front();
					results_seen++;
					if (sum_ch.value !== want.value || sum_ch.error !== want.error) begin
						error_count++;
						$display("%0t: mismatch, expected value %0d error %s, got value %0d error %s",
							$time, want.value, want.error.name(), sum_ch.value,
							sum_ch.error.name());
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_MAX_LENGTH: max_len_cfg = wr_data;
					REG_MIN_LENGTH: min_len_cfg = wr_data;
					default: ;
				endcase
			end
			if (char_ch.valid && char_ch.ready) begin
				chars_seen++;
				if (parse_char(char_ch.char_in, char_ch.last, pred)) begin
					note = answer_notes.pop_front();
					pending_sums.push_back(note.fixed ? note.r : pred);
				end
			end
		end
	end

	initial begin : result_sink
		sum_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				sum_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_offs_done++;
			end
			sum_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic drain(input int extra);
		while (pending_sums.size() != 0 || answer_notes.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_limits(input logic [7:0] max_len, input logic [7:0] min_len);
		char_ch.valid <= 1'b0;
		drain(SETTLE_CYCLES);
		wr_en    <= 1'b1;
		wr_index <= REG_MAX_LENGTH;
		wr_data  <= max_len;
		@(posedge clk);
		wr_index <= REG_MIN_LENGTH;
		wr_data  <= min_len;
		@(posedge clk);
		wr_en   <= 1'b0;
		max_set = max_len;
		min_set = min_len;
		settings_count++;
	endtask

	task automatic send_expression(input bit fixed, input parse_result_t r);
		answer_note_t note;
		note.fixed = fixed;
		note.r     = r;
		answer_notes.push_back(note);
		foreach (expr_bytes[i]) begin
			if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
				char_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while ($urandom_range(99) < send_gap_pct);
			end
			char_ch.valid   <= 1'b1;
			char_ch.char_in <= expr_bytes[i];
			char_ch.last    <= (i == expr_bytes.size() - 1);
			do
				@(posedge clk);
			while (!char_ch.ready);
		end
	endtask

	task automatic build_random_expression();
		string      hex_digits = "0123456789ABCDEF";
		string      tricky     = "abcdefxX -d";
		int         kind;
		int         terms;
		logic [7:0] b;
		expr_bytes.delete();
		kind  = $urandom_range(99);
		terms = (kind < 3) ? $urandom_range(40, 90) : $urandom_range(1, 5);
		for (int t = 0; t < terms; t++) begin
			if (t > 0 || $urandom_range(3) == 0)
				expr_bytes.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
			case ($urandom_range(9))
				0: ;
				1, 2, 3: begin
					expr_bytes.push_back(CHAR_ZERO);
					expr_bytes.push_back(CHAR_X);
					repeat ($urandom_range(10))
						expr_bytes.push_back(hex_digits[$urandom_range(15)]);
				end
				default: begin
					repeat ($urandom_range(1, 11))
						expr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
				end
			endcase
		end
		if (kind >= 3 && kind < 20) begin
			repeat ($urandom_range(1, 3)) begin
				b = $urandom_range(1) ? 8'($urandom_range(255))
					: 8'(tricky[$urandom_range(tricky.len() - 1)]);
				expr_bytes.insert($urandom_range(expr_bytes.size()), b);
			end
		end
		if (expr_bytes.size() == 0)
			expr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
	endtask

	function automatic string repeat_text(input string unit, input int n);
		string s = "";
		repeat (n) s = {s, unit};
		return s;
	endfunction

	initial begin : stimulus
		directed_row_t rows [$];
		parse_result_t fixed_r;
		logic [7:0]    phase_max [PHASES];
		logic [7:0]    phase_min [PHASES];
		int            phase_chars;

		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= REG_MAX_LENGTH;
		wr_data         <= '0;
		char_ch.valid   <= 1'b0;
		char_ch.char_in <= '0;
		char_ch.last    <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{8'd63, 8'd1, "", "0", 1'b1, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "", "+", 1'b1, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "-", "5", 1'b1, -5, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "2147483647+", "1", 1'b1, 32'h8000_0000, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "429496729", "5", 1'b1, 32'hFFFF_FFFF, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "0xFFFFFFF", "F", 1'b1, 32'hFFFF_FFFF, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "0", "x", 1'b1, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "0xAb", "c", 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "12", "x", 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "-", "d", 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "", 8'h00, 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "", 8'hFF, 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "0", "X", 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "00", "x", 1'b1, 0, ERR_MALFORMED});
		rows.push_back('{8'd63, 8'd1, "0x1F-0x0", "A", 1'b0, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "100-250+-", "7", 1'b0, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "--", "-", 1'b1, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, "1+0x10-9", "9", 1'b0, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd1, repeat_text("1", 63), "1", 1'b1, 0, ERR_TOO_LONG});
		rows.push_back('{8'd63, 8'd1, repeat_text("a", 63), "1", 1'b1, 0, ERR_TOO_LONG});
		rows.push_back('{8'd63, 8'd1, repeat_text("1+", 31), "1", 1'b0, 0, ERR_NONE});
		rows.push_back('{8'd63, 8'd5, "12", "3", 1'b1, 0, ERR_TOO_SHORT});
		rows.push_back('{8'd63, 8'd5, "1", "a", 1'b1, 0, ERR_TOO_SHORT});
		rows.push_back('{8'd3, 8'd5, "123", "4", 1'b1, 0, ERR_TOO_LONG});
		rows.push_back('{8'd0, 8'd0, "", "7", 1'b1, 0, ERR_TOO_LONG});
		rows.push_back('{8'd255, 8'd0, "", "7", 1'b1, 7, ERR_NONE});
		rows.push_back('{8'd255, 8'd255, repeat_text("1+", 149), "1", 1'b0, 0, ERR_NONE});
		rows.push_back('{8'd255, 8'd255, repeat_text("1", 253), "1", 1'b1, 0, ERR_TOO_SHORT});
		rows.push_back('{8'd254, 8'd1, repeat_text("1+", 149), "1", 1'b1, 0, ERR_TOO_LONG});

		foreach (rows[k]) begin
			if (rows[k].max_len != max_set || rows[k].min_len != min_set)
				set_limits(rows[k].max_len, rows[k].min_len);
			expr_bytes.delete();
			for (int j = 0; j < rows[k].head.len(); j++)
				expr_bytes.push_back(rows[k].head[j]);
			expr_bytes.push_back(rows[k].tail);
			fixed_r.value = rows[k].value;
			fixed_r.error = rows[k].error;
			send_expression(rows[k].fixed, fixed_r);
		end

		phase_max = '{8'd63, 8'd255, 8'd40, 8'd1, 8'd100, 8'd0, 8'd63, 8'd255};
		phase_min = '{8'd1, 8'd0, 8'd3, 8'd1, 8'd2, 8'd0, 8'd1, 8'd1};
		phase_max[6] = 8'($urandom_range(1, 255));
		phase_min[6] = 8'($urandom_range(1, phase_max[6]));

		for (int ph = 0; ph < PHASES; ph++) begin
			set_limits(phase_max[ph], phase_min[ph]);
			send_gap_pct = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 12 : 0;
			stall_pct    = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 12 : 0;
			if (ph == PRESSURE_PHASE)
				hold_off_req = 1'b1;
			phase_chars = 0;
			while (phase_chars < RANDOM_CHARS / PHASES) begin
				build_random_expression();
				phase_chars += expr_bytes.size();
				send_expression(1'b0, '0);
			end
		end

		char_ch.valid <= 1'b0;
		stall_pct = 0;
		drain(8);
		$display("Checked %0d result beats from %0d character beats under %0d length settings,",
			results_seen, chars_seen, settings_count);
		$display("with idle and stall phases and %0d long receiver hold-off.", hold_offs_done);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
